// ===== rtl/abfs_pkg.sv =====
// Package for the aligned best-fit suballocator.
// Holds sizes, widths and the binding table entry type; depends on nothing.
`default_nettype none

package abfs_pkg;

  // Table and chunk limits.
  localparam int MAX_BINDINGS = 64;
  localparam int MAX_CHUNKS   = 16;

  // Field widths.
  localparam int SIZE_W  = 32;
  localparam int ALIGN_W = 17;
  localparam int OFF_W   = 40;
  localparam int END_W   = OFF_W + 1;
  localparam int PAD_W   = 16;
  localparam int IDX_W   = $clog2(MAX_BINDINGS);
  localparam int CNT_W   = $clog2(MAX_BINDINGS + 1);
  localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
  localparam int PROD_W  = SIZE_W + CHUNK_W;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_CHUNK_BASE = 3'd0;
  localparam logic [SIZE_W-1:0] CHUNK_BASE_RESET = 32'd16777216;

  // Largest alignment honoured; larger requests are clamped to it.
  localparam logic [ALIGN_W-1:0] ALIGN_MAX = 17'd65536;

  // One binding of the table.
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/abfs_rem_unit.sv =====
// Iterative remainder unit: dividend modulo divisor, four bits per cycle.
// Depends on abfs_pkg for widths.
`default_nettype none

module abfs_rem_unit import abfs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [END_W-1:0]   dividend,
  input  wire logic [ALIGN_W-1:0] divisor,
  output logic                    busy,
  output logic [ALIGN_W-1:0]      rem
);

  localparam int DIG   = 4;
  localparam int STEPS = (END_W + DIG - 1) / DIG;
  localparam int SHW   = STEPS * DIG;
  localparam int STC_W = $clog2(STEPS + 1);

  logic [SHW-1:0]     sh;
  logic [ALIGN_W-1:0] div_r;
  logic [STC_W-1:0]   cnt;
  logic [ALIGN_W-1:0] rem_next;

  // Four restoring steps on the narrow remainder.
  always_comb begin
    logic [ALIGN_W:0]   t;
    logic [ALIGN_W-1:0] r;
    r = rem;
    for (int j = 0; j < DIG; j++) begin
      t = {r, sh[SHW-1-j]};
      if (t >= {1'b0, div_r}) begin
        r = ALIGN_W'(t - {1'b0, div_r});
      end else begin
        r = t[ALIGN_W-1:0];
      end
    end
    rem_next = r;
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= STC_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= SHW'(dividend);
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      sh  <= sh << DIG;
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/abfs_table.sv =====
// Binding table memory: one write port and one registered read port.
// Depends on abfs_pkg for the entry type.
`default_nettype none

module abfs_table import abfs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [MAX_BINDINGS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/aligned_best_fit_suballocator.sv =====
// Channel  | Signals                               | Direction
// request  | in_valid, in_stall, req_size, align   | in
// result   | out_valid, out_stall, chunk_index,    | out
//          | binding_slot, alloc_offset, pad_bytes,|
//          | new_chunk, status                     |
// config   | psel, penable, pwrite, paddr, pwdata, | in / out
//          | prdata, pready                        |
//
// One item at a time: in_stall is high from acceptance until the result is loaded.
// The time an item takes grows with the bindings scanned and with those moved up for
// the sorted insert; the shared remainder unit (11 steps) and the single read port of
// the table set it. A request whose scan fails opens a new chunk after the scan.
// Reset is synchronous; it empties the table and restores the base size.
// A result waits in its output register while out_stall is high.
// Top level; depends on abfs_pkg, abfs_rem_unit and abfs_table.
`default_nettype none

module aligned_best_fit_suballocator import abfs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SIZE_W-1:0]  req_size,
  input  wire logic [ALIGN_W-1:0] align,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              chunk_index,
  output logic [5:0]              binding_slot,
  output logic [OFF_W-1:0]        alloc_offset,
  output logic [PAD_W-1:0]        pad_bytes,
  output logic                    new_chunk,
  output logic                    status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_LOAD0  = 4'd3;
  localparam logic [3:0] ST_NEXT   = 4'd4;
  localparam logic [3:0] ST_MOD    = 4'd5;
  localparam logic [3:0] ST_EVAL   = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_OPEN   = 4'd8;
  localparam logic [3:0] ST_INSERT = 4'd9;
  localparam logic [3:0] ST_SHIFT  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam logic [END_W-1:0] SIZE_SAT = {1'b0, {OFF_W{1'b1}}};

  logic [3:0]         state;
  logic [SIZE_W-1:0]  chunk_base;
  logic [SIZE_W-1:0]  size_r;
  logic [ALIGN_W-1:0] al_r;
  logic [CHUNK_W-1:0] chunks_used;
  logic [OFF_W-1:0]   cur_size;
  logic [CNT_W-1:0]   count;
  logic               opened;
  logic [IDX_W-1:0]   idx;
  logic [END_W-1:0]   e_end;
  entry_t             n_ent;
  logic [END_W-1:0]   gap;
  logic               found;
  logic [END_W-1:0]   best;
  logic [OFF_W-1:0]   off_r;
  logic [PAD_W-1:0]   pad_r;
  logic [PAD_W-1:0]   pad_cur;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   k;
  logic [PROD_W-1:0]  prod;
  logic               status_r;
  logic [5:0]         slot_r;

  logic               rem_busy;
  logic [ALIGN_W-1:0] rem;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr;
  entry_t             tbl_wdata;
  logic [IDX_W-1:0]   tbl_raddr;
  entry_t             tbl_rdata;

  logic               in_acc;
  logic               has_next;
  logic [ALIGN_W-1:0] al_norm;
  logic [SIZE_W-1:0]  base_eff;
  logic [SIZE_W:0]    need;
  logic [END_W-1:0]   new_size;
  logic [END_W-1:0]   nxt_pos;
  logic               out_load;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign pready   = 1'b1;
  assign has_next = ({1'b0, idx} + 1'b1) < count;
  assign base_eff = (chunk_base == '0) ? SIZE_W'(1) : chunk_base;
  assign need     = {1'b0, size_r} + (SIZE_W + 1)'(pad_cur);
  assign new_size = END_W'(prod) + END_W'(size_r) + END_W'(al_r);
  assign nxt_pos  = has_next ? END_W'(tbl_rdata.offset) : END_W'(cur_size);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // Alignment clamp: zero means one, large values stop at the maximum.
  always_comb begin
    if (align == '0) begin
      al_norm = ALIGN_W'(1);
    end else if (align > ALIGN_MAX) begin
      al_norm = ALIGN_MAX;
    end else begin
      al_norm = align;
    end
  end

  // Configuration register and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_base <= CHUNK_BASE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_CHUNK_BASE) begin
      chunk_base <= pwdata;
    end
  end

  assign prdata = (paddr == REG_CHUNK_BASE) ? chunk_base : '0;

  // Table access: reads run one entry ahead of the scan or the shift.
  always_comb begin
    tbl_raddr = '0;
    tbl_we    = 1'b0;
    tbl_waddr = k[IDX_W-1:0];
    tbl_wdata = tbl_rdata;
    unique case (state)
      ST_LOAD0:  tbl_raddr = IDX_W'(1);
      ST_EVAL:   tbl_raddr = idx + IDX_W'(2);
      ST_INSERT: begin
        tbl_raddr = IDX_W'(k - 1'b1);
        if (!(k > pos)) begin
          tbl_we           = 1'b1;
          tbl_waddr        = pos[IDX_W-1:0];
          tbl_wdata.offset = off_r;
          tbl_wdata.size   = size_r;
        end
      end
      ST_SHIFT:  tbl_we = 1'b1;
      default:   tbl_raddr = '0;
    endcase
  end

  abfs_table u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  abfs_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_NEXT),
    .dividend (e_end),
    .divisor  (al_r),
    .busy     (rem_busy),
    .rem      (rem)
  );

  // Result valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer: open, scan, place, insert, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chunks_used <= '0;
      cur_size    <= '0;
      count       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            size_r   <= req_size;
            al_r     <= al_norm;
            opened   <= 1'b0;
            status_r <= 1'b0;
            found    <= 1'b0;
            state    <= ST_START;
          end
        end
        ST_START: begin
          if (chunks_used == '0) begin
            chunks_used <= CHUNK_W'(1);
            cur_size    <= OFF_W'(base_eff);
            count       <= '0;
            opened      <= 1'b1;
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          idx <= '0;
          if (OFF_W'(size_r) > cur_size || count >= CNT_W'(MAX_BINDINGS)) begin
            state <= ST_MUL;
          end else if (count == '0) begin
            off_r <= '0;
            pad_r <= '0;
            pos   <= '0;
            k     <= '0;
            state <= ST_INSERT;
          end else begin
            state <= ST_LOAD0;
          end
        end
        ST_LOAD0: begin
          e_end <= END_W'(tbl_rdata.offset) + END_W'(tbl_rdata.size);
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          n_ent <= tbl_rdata;
          gap   <= (nxt_pos >= e_end) ? nxt_pos - e_end : '0;
          state <= ST_MOD;
        end
        ST_MOD: begin
          if (!rem_busy) begin
            pad_cur <= (rem == '0) ? '0 : PAD_W'(al_r - rem);
            state   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (gap >= END_W'(need) && (!found || gap < best)) begin
            found <= 1'b1;
            best  <= gap;
            off_r <= OFF_W'(e_end + END_W'(pad_cur));
            pad_r <= pad_cur;
            pos   <= CNT_W'(idx) + 1'b1;
          end
          if (has_next) begin
            idx   <= idx + 1'b1;
            e_end <= END_W'(n_ent.offset) + END_W'(n_ent.size);
            state <= ST_NEXT;
          end else if (found || (gap >= END_W'(need))) begin
            k     <= count;
            state <= ST_INSERT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(base_eff) * PROD_W'(chunks_used);
          state <= ST_OPEN;
        end
        ST_OPEN: begin
          if (chunks_used >= CHUNK_W'(MAX_CHUNKS)) begin
            status_r <= 1'b1;
            state    <= ST_OUT;
          end else begin
            cur_size    <= (new_size > SIZE_SAT) ? OFF_W'(SIZE_SAT) : OFF_W'(new_size);
            chunks_used <= chunks_used + 1'b1;
            count       <= '0;
            opened      <= 1'b1;
            off_r       <= '0;
            pad_r       <= '0;
            pos         <= '0;
            k           <= '0;
            state       <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (k > pos) begin
            state <= ST_SHIFT;
          end else begin
            slot_r <= 6'(count);
            count  <= count + 1'b1;
            state  <= ST_OUT;
          end
        end
        ST_SHIFT: begin
          k     <= k - 1'b1;
          state <= ST_INSERT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register, loaded as the item leaves the sequencer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      new_chunk <= opened;
      status    <= status_r;
      if (status_r) begin
        chunk_index  <= '0;
        binding_slot <= '0;
        alloc_offset <= '0;
        pad_bytes    <= '0;
      end else begin
        chunk_index  <= 4'(chunks_used - 1'b1);
        binding_slot <= slot_r;
        alloc_offset <= off_r;
        pad_bytes    <= pad_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/abfs_checker.sv =====
// Port-level checks for the suballocator and the bind that attaches them.
// Depends on abfs_pkg and the top level's ports.
`default_nettype none

module abfs_checker import abfs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [3:0]        chunk_index,
  input wire logic [5:0]        binding_slot,
  input wire logic [OFF_W-1:0]  alloc_offset,
  input wire logic [PAD_W-1:0]  pad_bytes,
  input wire logic              new_chunk,
  input wire logic              status
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alloc_offset) && $stable(status))
    else $error("result changed while stalled");

  // One item at a time: an accepted item makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting an item");

  // A refused request carries no placement.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> alloc_offset == '0 && pad_bytes == '0 &&
      chunk_index == '0 && binding_slot == '0)
    else $error("refused request carries a placement");

  // A successful request in a freshly opened chunk sits at its start.
  a_new_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_chunk && !status |-> alloc_offset == '0 && binding_slot == '0)
    else $error("new chunk placement not at offset zero");

endmodule

bind aligned_best_fit_suballocator abfs_checker u_abfs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chunk_index  (chunk_index),
  .binding_slot (binding_slot),
  .alloc_offset (alloc_offset),
  .pad_bytes    (pad_bytes),
  .new_chunk    (new_chunk),
  .status       (status)
);

`default_nettype wire
